FILE: hdl/set_assoc_cache_lru_tag_controller_core_defines.svh
// assertion macros of the cache tag controller rtl
// no dependencies; included by salc_ctrl, which checks its own logic
`ifndef SET_ASSOC_CACHE_LRU_TAG_CONTROLLER_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TAG_CONTROLLER_CORE_DEFINES_SVH

// implication checked on every rising edge out of reset
`define SALC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never hold, checked also in reset
`define SALC_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) !(cond)) else $error(msg);

`endif

FILE: hdl/salc_pkg.sv
// types, constants and codes of the cache tag controller
// no dependencies; used by every module of the block
`default_nettype none

package salc_pkg;

   localparam int LANES     = 16;
   localparam int LANE_W    = 4;
   localparam int ROWS      = 4096;
   localparam int ROW_W     = 12;
   localparam int TAG_W     = 18;

   localparam logic       OP_READ  = 1'b0;
   localparam logic       OP_WRITE = 1'b1;
   localparam logic [1:0] POL_WB   = 2'd0;
   localparam logic [1:0] POL_WTA  = 2'd1;

   localparam logic [1:0] REG_BLOCK  = 2'd0;
   localparam logic [1:0] REG_WAYS   = 2'd1;
   localparam logic [1:0] REG_POLICY = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [31:0] address;
      logic [2:0] byte_count;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] way;
      logic       allocated;
      logic       victim_valid;
      logic       dirty_writeback;
      logic       write_through;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             valid;
      logic             dirty;
      logic [3:0]       rank;
   } lane_type;

   typedef lane_type [LANES-1:0] row_type;

   typedef struct packed {
      logic [1:0] log2_block_words;
      logic [2:0] log2_ways;
      logic [1:0] write_policy;
   } cfg_type;

   typedef struct packed {
      logic             load;
      logic             clr_we;
      logic [ROW_W-1:0] clr_row;
      logic             second;
      logic             rd;
      logic             eval;
      logic             upd;
   } cmd_type;

   typedef struct packed {
      logic two_blocks;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: hdl/salc_ctrl.sv
// controller state machine of the cache tag controller: clear sweep and block sequence
// depends on salc_pkg and the assertion macro header
`default_nettype none
`include "set_assoc_cache_lru_tag_controller_core_defines.svh"

module salc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               geo_wr,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire salc_pkg::stat_type stat,
   output salc_pkg::cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [salc_pkg::ROW_W-1:0] clr_ff, clr_in;
   logic                       second_ff, second_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.clr_row = clr_ff;
      cmd.second  = second_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_we = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == salc_pkg::ROW_W'(salc_pkg::ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               second_in = 1'b0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (stat.out_free) begin
               cmd.upd = 1'b1;
               if (stat.two_blocks && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (geo_wr) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         second_ff <= second_in;
      end
   end

   `SALC_ASSERT(a_accept_reads, (req_valid && req_ready && !geo_wr) |=> (state_ff == S_READ), "accepted word not followed by a tag read")
   `SALC_ASSERT(a_eval_then_upd, (state_ff == S_EVAL && !geo_wr) |=> (state_ff == S_UPD), "evaluation not followed by update")
   `SALC_NEVER(a_clear_excl, cmd.clr_we && (cmd.upd || cmd.rd || cmd.load), "clear sweep overlaps block work")
   `SALC_ASSERT(a_second_once, (cmd.upd && second_ff) |=> (state_ff != S_READ || geo_wr || cmd.load == 1'b0), "third block started")

endmodule

`default_nettype wire

FILE: hdl/salc_dp.sv
// datapath of the cache tag controller: tag/state memory, compare, lru update, result register
// depends on salc_pkg
`default_nettype none

module salc_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire salc_pkg::cfg_type  cfg,
   input  wire salc_pkg::cmd_type  cmd,
   output salc_pkg::stat_type      stat,
   input  wire salc_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output salc_pkg::rsp_type       rsp_data
);

   salc_pkg::row_type mem [salc_pkg::ROWS];

   logic [2:0] lwe;
   logic [3:0] nm1;
   logic [2:0] sh;
   logic [2:0] cnt;
   logic [31:0] last_addr;

   logic        op_ff;
   logic [31:0] first_ff, lastb_ff;
   logic        two_ff;

   logic [31:0] sel_addr;
   logic [15:0] base;
   logic [salc_pkg::ROW_W-1:0] row_ff;
   logic [3:0]  off_ff;
   logic [salc_pkg::TAG_W-1:0] tag_ff;
   salc_pkg::row_type rdata_ff;

   logic       hit_c, vfound_c;
   logic [3:0] hit_l_c, vic_l_c;
   logic       hit_ff;
   logic [3:0] hit_l_ff, vic_l_ff;

   salc_pkg::row_type new_row, clr_row;
   logic       alloc;
   logic [3:0] sel_l;
   logic [3:0] old_rank;
   logic       wmark;

   logic               rsp_valid_ff;
   salc_pkg::rsp_type  rsp_ff;

   assign lwe = (cfg.log2_ways > 3'd4) ? 3'd4 : cfg.log2_ways;
   assign nm1 = 4'((5'd1 << lwe) - 5'd1);
   assign sh  = 3'd2 + {1'b0, cfg.log2_block_words};

   always_comb begin
      if (req_data.byte_count == 3'd0) begin
         cnt = 3'd1;
      end else if (req_data.byte_count > 3'd4) begin
         cnt = 3'd4;
      end else begin
         cnt = req_data.byte_count;
      end
   end
   assign last_addr = req_data.address + 32'(cnt) - 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         first_ff <= req_data.address;
         lastb_ff <= last_addr;
         two_ff   <= (req_data.address >> sh) != (last_addr >> sh);
      end
   end

   // set index wraps at the number of sets of the current geometry
   assign sel_addr = cmd.second ? lastb_ff : first_ff;
   assign base     = 16'((sel_addr >> sh) << lwe) & (16'hffff >> cfg.log2_block_words);

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         row_ff   <= base[15:4];
         off_ff   <= base[3:0];
         tag_ff   <= salc_pkg::TAG_W'(sel_addr >> (5'd18 - {2'b0, lwe}));
         rdata_ff <= mem[base[15:4]];
      end
   end

   always_comb begin
      hit_c    = 1'b0;
      vfound_c = 1'b0;
      hit_l_c  = off_ff;
      vic_l_c  = off_ff;
      for (int l = salc_pkg::LANES - 1; l >= 0; l--) begin
         if ((4'(l) & ~nm1) == off_ff) begin
            if (rdata_ff[l].valid && rdata_ff[l].tag == tag_ff) begin
               hit_c   = 1'b1;
               hit_l_c = 4'(l);
            end
            if (rdata_ff[l].rank == nm1) begin
               vfound_c = 1'b1;
               vic_l_c  = 4'(l);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         hit_ff   <= hit_c;
         hit_l_ff <= hit_l_c;
         vic_l_ff <= vfound_c ? vic_l_c : off_ff;
      end
   end

   assign alloc    = !hit_ff && (op_ff == salc_pkg::OP_READ
                                 || cfg.write_policy <= salc_pkg::POL_WTA);
   assign sel_l    = hit_ff ? hit_l_ff : vic_l_ff;
   assign old_rank = rdata_ff[sel_l].rank;
   assign wmark    = (op_ff == salc_pkg::OP_WRITE) && (cfg.write_policy == salc_pkg::POL_WB);

   always_comb begin
      new_row = rdata_ff;
      if (hit_ff || alloc) begin
         for (int l = 0; l < salc_pkg::LANES; l++) begin
            if ((4'(l) & ~nm1) == off_ff && 4'(l) != sel_l
                && rdata_ff[l].rank < old_rank) begin
               new_row[l].rank = rdata_ff[l].rank + 4'd1;
            end
         end
         new_row[sel_l].rank = 4'd0;
      end
      if (hit_ff && wmark) begin
         new_row[sel_l].dirty = 1'b1;
      end
      if (alloc) begin
         new_row[sel_l].tag   = tag_ff;
         new_row[sel_l].valid = 1'b1;
         new_row[sel_l].dirty = wmark;
      end
   end

   always_comb begin
      for (int l = 0; l < salc_pkg::LANES; l++) begin
         clr_row[l]      = '0;
         clr_row[l].rank = 4'(l) & nm1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         mem[cmd.clr_row] <= clr_row;
      end else if (cmd.upd) begin
         mem[row_ff] <= new_row;
      end
   end

   assign stat.two_blocks = two_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.upd) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         rsp_ff.hit             <= hit_ff;
         rsp_ff.way             <= (hit_ff || alloc) ? (sel_l & nm1) : 4'd0;
         rsp_ff.allocated       <= alloc;
         rsp_ff.victim_valid    <= alloc && rdata_ff[vic_l_ff].valid;
         rsp_ff.dirty_writeback <= alloc && rdata_ff[vic_l_ff].valid
                                   && rdata_ff[vic_l_ff].dirty;
         rsp_ff.write_through   <= (op_ff == salc_pkg::OP_WRITE)
                                   && (cfg.write_policy != salc_pkg::POL_WB);
         rsp_ff.last            <= !two_ff || cmd.second;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/set_assoc_cache_lru_tag_controller_core.sv
// top level of the set-associative cache tag controller: register port and instances
// depends on salc_pkg, salc_ctrl and salc_dp
//
// channel   direction  handshake          word
// req       in         req_valid/ready    salc_pkg::req_type
// rsp       out        rsp_valid/ready    salc_pkg::rsp_type
// csr       in         psel/penable       32-bit registers at 0x0, 0x4, 0x8
//
// each block takes a read, an evaluate and an update state; a word that spans two blocks
// runs that sequence once per block, and no new word is accepted until the sequence is done
// after reset and after each geometry write a clear sweep over all 4096 rows runs, no word accepted
// a full result register holds the update cycle until rsp_ready
`default_nettype none

module set_assoc_cache_lru_tag_controller_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire salc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output salc_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   salc_pkg::cfg_type  cfg_ff;
   salc_pkg::cmd_type  cmd;
   salc_pkg::stat_type stat;
   logic               wr;
   logic               geo_wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign geo_wr = wr && (paddr[3:2] == salc_pkg::REG_BLOCK || paddr[3:2] == salc_pkg::REG_WAYS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr) begin
         unique case (paddr[3:2])
            salc_pkg::REG_BLOCK:  cfg_ff.log2_block_words <= pwdata[1:0];
            salc_pkg::REG_WAYS:   cfg_ff.log2_ways        <= pwdata[2:0];
            salc_pkg::REG_POLICY: cfg_ff.write_policy     <= pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         salc_pkg::REG_BLOCK:  prdata = {30'd0, cfg_ff.log2_block_words};
         salc_pkg::REG_WAYS:   prdata = {29'd0, cfg_ff.log2_ways};
         salc_pkg::REG_POLICY: prdata = {30'd0, cfg_ff.write_policy};
         default:              prdata = '0;
      endcase
   end

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .geo_wr    (geo_wr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   salc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
